FILE: rtl/core/caq_pkg.sv
// caq_pkg: shared types, codes and helpers of the capacity admission queue
// used by caq_ctrl, caq_dp and capacity_admission_queue_core; no dependencies
package caq_pkg;

  localparam int AMT_W = 32;
  localparam int ID_W = 16;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 4;

  // most retry ids handed out by one drain
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd3;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 4'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED = 4'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 4'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 4'd3;
  localparam logic [STATUS_W-1:0] ST_HEAD_FITS = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_FITS = 4'd5;
  localparam logic [STATUS_W-1:0] ST_RETRY_ID = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NO_RETRY = 4'd7;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 4'd8;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 4'd9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [AMT_W-1:0] amt;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic drain_step;
  } cmd_t;

  typedef struct packed {
    logic drain_go;
    logic drain_done;
    logic out_free;
  } sts_t;

  // budget left over above taken, zero when capacity sits at or below it
  function automatic logic [AMT_W-1:0] unused_budget(input logic [AMT_W-1:0] cap,
                                                     input logic [AMT_W-1:0] taken);
    logic [AMT_W-1:0] res;
    res = (taken >= cap) ? '0 : cap - taken;
    return res;
  endfunction

endpackage

FILE: rtl/core/caq_ctrl.sv
// caq_ctrl: sequencing state machine of the capacity admission queue
// depends on caq_pkg; drives commands into caq_dp and reads its status
module caq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  caq_pkg::sts_t sts,
  output caq_pkg::cmd_t cmd
);

  caq_pkg::state_t state_r;
  caq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= caq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      caq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = caq_pkg::S_EXEC;
        end
      end
      caq_pkg::S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = sts.drain_go ? caq_pkg::S_DRAIN : caq_pkg::S_IDLE;
        end
      end
      caq_pkg::S_DRAIN: begin
        if (sts.out_free && sts.drain_done) begin
          state_nxt = caq_pkg::S_IDLE;
        end
      end
      default: state_nxt = caq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd = '0;
    case (state_r)
      caq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load_item = in_valid;
      end
      caq_pkg::S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      caq_pkg::S_DRAIN: begin
        cmd.drain_step = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/core/caq_dp.sv
// caq_dp: budget, waiter fifo, drain walker and output register
// depends on caq_pkg; commanded by caq_ctrl
module caq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  caq_pkg::cmd_t                cmd,
  output caq_pkg::sts_t                sts,
  input  logic                         cfg_wr_en,
  input  logic [caq_pkg::AMT_W-1:0]    cfg_wr_data,
  input  logic [caq_pkg::MODE_W-1:0]   in_mode,
  input  logic [caq_pkg::ID_W-1:0]     in_requester_id,
  input  logic [caq_pkg::AMT_W-1:0]    in_amount,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [caq_pkg::STATUS_W-1:0] out_status,
  output logic [caq_pkg::ID_W-1:0]     out_released_id,
  output logic                         out_last
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

  // budget and queue control
  logic [caq_pkg::AMT_W-1:0] cap_r, cap_nxt;
  logic [caq_pkg::AMT_W-1:0] used_r, used_nxt;
  logic [PTR_W-1:0]          head_r, head_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      stopped_r, stopped_nxt;

  // latched transaction
  logic [caq_pkg::MODE_W-1:0] mode_r;
  logic [caq_pkg::ID_W-1:0]   rid_r;
  logic [caq_pkg::AMT_W-1:0]  amt_r;

  // drain walker
  logic [caq_pkg::AMT_W-1:0] run_r, run_nxt;
  logic [caq_pkg::NRES_W-1:0] nres_r, nres_nxt;
  logic                      pend_r, pend_nxt;
  logic [caq_pkg::ID_W-1:0]  pend_id_r, pend_id_nxt;

  // output register
  logic                         oval_r, oval_nxt;
  logic [caq_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic [caq_pkg::ID_W-1:0]     oid_r, oid_nxt;
  logic                         olast_r, olast_nxt;
  logic                         out_load;

  // waiter memory
  caq_pkg::entry_t  mem [QUEUE_DEPTH];
  caq_pkg::entry_t  rd_r;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [SUM_W-1:0] slot_sum;

  logic [caq_pkg::AMT_W-1:0] rel_used;
  logic                      drain_fit;

  assign slot_sum = {1'b0, head_r} + SUM_W'(count_r);
  assign wr_addr = (slot_sum >= DEPTH_SUM) ? PTR_W'(slot_sum - DEPTH_SUM)
                                           : PTR_W'(slot_sum);
  assign rel_used = (used_r >= amt_r) ? used_r - amt_r : '0;

  assign drain_fit = (count_r != '0) &&
                     (nres_r < caq_pkg::NRES_W'(caq_pkg::MAX_RESULTS)) &&
                     (rd_r.amt <= caq_pkg::unused_budget(cap_r, run_r));

  assign sts.out_free = !oval_r || !out_stall;
  assign sts.drain_go = (mode_r == caq_pkg::MODE_DRAIN) && !stopped_r;
  assign sts.drain_done = !drain_fit;

  always_comb begin
    cap_nxt = cfg_wr_en ? cfg_wr_data : cap_r;
    used_nxt = used_r;
    head_nxt = head_r;
    count_nxt = count_r;
    stopped_nxt = stopped_r;
    run_nxt = run_r;
    nres_nxt = nres_r;
    pend_nxt = pend_r;
    pend_id_nxt = pend_id_r;
    wr_en = 1'b0;
    out_load = 1'b0;
    ost_nxt = ost_r;
    oid_nxt = '0;
    olast_nxt = 1'b1;

    if (cmd.exec) begin
      out_load = 1'b1;
      case (mode_r)
        caq_pkg::MODE_REQUEST: begin
          if (stopped_r) begin
            ost_nxt = caq_pkg::ST_REFUSED;
          end else if (amt_r > cap_r) begin
            ost_nxt = caq_pkg::ST_TOO_LARGE;
          end else if (amt_r <= caq_pkg::unused_budget(cap_r, used_r)) begin
            ost_nxt = caq_pkg::ST_GRANTED;
            used_nxt = used_r + amt_r;
          end else if (count_r == FULL_CNT) begin
            ost_nxt = caq_pkg::ST_QUEUE_FULL;
          end else begin
            ost_nxt = caq_pkg::ST_QUEUED;
            wr_en = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        caq_pkg::MODE_RELEASE: begin
          used_nxt = rel_used;
          if ((count_r != '0) && (rd_r.amt <= caq_pkg::unused_budget(cap_r, rel_used))) begin
            ost_nxt = caq_pkg::ST_HEAD_FITS;
          end else begin
            ost_nxt = caq_pkg::ST_NONE_FITS;
          end
        end
        caq_pkg::MODE_DRAIN: begin
          if (stopped_r) begin
            ost_nxt = caq_pkg::ST_REFUSED;
          end else begin
            // walker starts; results come from the drain steps
            out_load = 1'b0;
            run_nxt = used_r;
            nres_nxt = '0;
            pend_nxt = 1'b0;
          end
        end
        caq_pkg::MODE_STOP: begin
          ost_nxt = caq_pkg::ST_STOPPED;
          stopped_nxt = 1'b1;
          head_nxt = '0;
          count_nxt = '0;
        end
        default: ost_nxt = caq_pkg::ST_REFUSED;
      endcase
    end else if (cmd.drain_step) begin
      if (drain_fit) begin
        run_nxt = run_r + rd_r.amt;
        nres_nxt = nres_r + 1'b1;
        head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
        count_nxt = count_r - 1'b1;
        pend_nxt = 1'b1;
        pend_id_nxt = rd_r.id;
        // previous id is known not to be the final one now
        out_load = pend_r;
        ost_nxt = caq_pkg::ST_RETRY_ID;
        oid_nxt = pend_id_r;
        olast_nxt = 1'b0;
      end else begin
        out_load = 1'b1;
        pend_nxt = 1'b0;
        if (pend_r) begin
          ost_nxt = caq_pkg::ST_RETRY_ID;
          oid_nxt = pend_id_r;
        end else begin
          ost_nxt = caq_pkg::ST_NO_RETRY;
        end
      end
    end

    if (out_load) begin
      oval_nxt = 1'b1;
    end else if (oval_r && !out_stall) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '1;
      used_r <= '0;
      head_r <= '0;
      count_r <= '0;
      stopped_r <= 1'b0;
      nres_r <= '0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      cap_r <= cap_nxt;
      used_r <= used_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
      stopped_r <= stopped_nxt;
      nres_r <= nres_nxt;
      pend_r <= pend_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    pend_id_r <= pend_id_nxt;
    if (cmd.load_item) begin
      mode_r <= in_mode;
      rid_r <= in_requester_id;
      amt_r <= in_amount;
    end
    if (out_load) begin
      ost_r <= ost_nxt;
      oid_r <= oid_nxt;
      olast_r <= olast_nxt;
    end
  end

  // read port follows the next head so a pop shows in rd_r in the cycle after it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{id: rid_r, amt: amt_r};
    end
    rd_r <= mem[head_nxt];
  end

  assign out_valid = oval_r;
  assign out_status = ost_r;
  assign out_released_id = oid_r;
  assign out_last = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("waiter count beyond queue depth");

  a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (count_r == '0))
    else $error("waiters present after stop");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && out_stall) |-> !out_load)
    else $error("stalled result overwritten");

  a_drain_limit: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= caq_pkg::NRES_W'(caq_pkg::MAX_RESULTS))
    else $error("drain handed out too many ids");

  a_pop_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.drain_step && drain_fit) |=> (count_r == $past(count_r) - 1'b1))
    else $error("drain pop did not shrink the queue");

endmodule

FILE: rtl/core/capacity_admission_queue_core.sv
// capacity_admission_queue_core: top level of the capacity admission queue
// depends on caq_pkg, caq_ctrl and caq_dp
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | mode, requester_id, amount
//   out_    | output    | out_valid / out_stall| status, released_id, last
//   cfg_    | input     | cfg_wr_en            | cfg_wr_data (capacity)
//
// request, release and stop pass the accept cycle in S_IDLE, then an execute step in S_EXEC
// that loads the result register once the output is free
// a drain passes the accept cycle, the execute step, a drain step for each id handed out and a
// closing step for the final result; while the output is free the walker pops one fifo entry
// per cycle through the memory's registered read port
// reset is synchronous, sets capacity to all ones, clears used budget, fifo pointers and stop flag; no clearing pass
// a stalled output holds the walker; a new transaction is accepted while a result waits
module capacity_admission_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [caq_pkg::AMT_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [caq_pkg::MODE_W-1:0]   in_mode,
  input  logic [caq_pkg::ID_W-1:0]     in_requester_id,
  input  logic [caq_pkg::AMT_W-1:0]    in_amount,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [caq_pkg::STATUS_W-1:0] out_status,
  output logic [caq_pkg::ID_W-1:0]     out_released_id,
  output logic                         out_last
);

  caq_pkg::cmd_t cmd;
  caq_pkg::sts_t sts;

  caq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  caq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_mode         (in_mode),
    .in_requester_id (in_requester_id),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_released_id (out_released_id),
    .out_last        (out_last)
  );

endmodule
